// File: design/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and constants shared by the Q24.8 fixed-point ALU and its divider.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Fractional bits of the fixed-point format
  localparam int unsigned FRAC_BITS = 8;
  // Quotient width of the divider: magnitude of a scaled by 2^FRAC_BITS
  localparam int unsigned QW        = 32 + FRAC_BITS;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_EQ       = 4'd4,
    OP_NE       = 4'd5,
    OP_LT       = 4'd6,
    OP_GT       = 4'd7,
    OP_LE       = 4'd8,
    OP_GE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               compare_true;
    logic               divide_by_zero;
  } alu_out_t;

  // Side info carried alongside the divider datapath
  typedef struct packed {
    logic [31:0] res;     // result for all non-divide ops
    logic        cmp;
    logic        dz;
    logic        is_div;  // divide with nonzero divisor
    logic        neg;     // quotient sign
  } div_tag_t;

endpackage

// File: design/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// ----------------------------------------------------------------------------
module fpa_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [fpa_pkg::QW-1:0]     dmag_i,
  input  logic [31:0]                bmag_i,
  input  fpa_pkg::div_tag_t          tag_i,
  output logic                       valid_o,
  output logic [fpa_pkg::QW-1:0]     quo_o,
  output fpa_pkg::div_tag_t          tag_o
);
  import fpa_pkg::*;

  logic              v_q   [QW];
  logic [31:0]       rem_q [QW];
  logic [QW-1:0]     d_q   [QW];
  logic [31:0]       b_q   [QW];
  div_tag_t          tag_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic          v_in;
    logic [31:0]   rem_in;
    logic [QW-1:0] d_in;
    logic [31:0]   b_in;
    div_tag_t      tag_in;
    logic [32:0]   rem_sh;
    logic [32:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign d_in   = dmag_i;
      assign b_in   = bmag_i;
      assign tag_in = tag_i;
    end else begin : g_rest
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign d_in   = d_q[s-1];
      assign b_in   = b_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    // shift in next dividend bit, trial subtract
    assign rem_sh = {rem_in, d_in[QW-1]};
    assign ge     = (rem_sh >= {1'b0, b_in});
    assign diff   = rem_sh - {1'b0, b_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[31:0] : rem_sh[31:0];
        d_q[s]   <= {d_in[QW-2:0], ge};
        b_q[s]   <= b_in;
        tag_q[s] <= tag_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = d_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

// File: design/fixed_point_q24_8_alu.sv
// Each beat passes the decode stage, the scaling stage, the divider stages and the output register.
// Throughput: one beat per cycle unless the output stalls; the divider has one stage per quotient bit.
// All ops travel the same pipeline so results leave in order.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed Q24.8 ALU: add, sub, mul, div, compares, min/max, inc/dec, int conversions.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fpa_pkg::alu_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fpa_pkg::alu_out_t out_o
);
  import fpa_pkg::*;

  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- stage 1: decode, compare, multiply ----------------
  op_e                op;
  logic signed [31:0] a, b;
  logic [31:0]        simple_d;
  logic               cmp_d;
  logic [31:0]        amag, bmag;

  assign op = op_e'(in_i.kind);
  assign a  = in_i.operand_a;
  assign b  = in_i.operand_b;
  assign amag = a[31] ? (~a + 32'd1) : a;
  assign bmag = b[31] ? (~b + 32'd1) : b;

  always_comb begin
    simple_d = '0;
    cmp_d    = 1'b0;
    case (op)
      OP_ADD:      simple_d = a + b;
      OP_SUB:      simple_d = a - b;
      OP_EQ:       cmp_d = (a == b);
      OP_NE:       cmp_d = (a != b);
      OP_LT:       cmp_d = (a < b);
      OP_GT:       cmp_d = (a > b);
      OP_LE:       cmp_d = (a <= b);
      OP_GE:       cmp_d = (a >= b);
      OP_MIN:      simple_d = (a > b) ? b : a;
      OP_MAX:      simple_d = (a < b) ? b : a;
      OP_INC:      simple_d = a + 32'sd1;
      OP_DEC:      simple_d = a - 32'sd1;
      OP_TO_INT:   simple_d = a >>> FRAC_BITS;
      OP_FROM_INT: simple_d = a << FRAC_BITS;
      default:     simple_d = '0;
    endcase
  end

  logic               v1_q;
  logic               mul1_q, div1_q, dz1_q, neg1_q, cmp1_q;
  logic [31:0]        simple1_q, bmag1_q;
  logic [QW-1:0]      dmag1_q;
  logic signed [63:0] prod1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul1_q    <= (op == OP_MUL);
      div1_q    <= (op == OP_DIV) && (b != 32'sd0);
      dz1_q     <= (op == OP_DIV) && (b == 32'sd0);
      neg1_q    <= a[31] ^ b[31];
      cmp1_q    <= cmp_d;
      simple1_q <= simple_d;
      bmag1_q   <= bmag;
      dmag1_q   <= {amag, {FRAC_BITS{1'b0}}};
      prod1_q   <= a * b;
    end
  end

  // ---------------- stage 2: multiply scaling, tag build ----------------
  logic signed [63:0] prod_adj;
  logic [31:0]        mulres;
  div_tag_t           tag2_d, tag2_q;
  logic               v2_q;
  logic [QW-1:0]      dmag2_q;
  logic [31:0]        bmag2_q;

  // truncate toward zero: bias negatives before the arithmetic shift
  assign prod_adj = prod1_q + (prod1_q[63] ? 64'sd2**FRAC_BITS - 64'sd1 : 64'sd0);
  assign mulres   = prod_adj[FRAC_BITS+31:FRAC_BITS];

  always_comb begin
    tag2_d.res    = mul1_q ? mulres : simple1_q;
    tag2_d.cmp    = cmp1_q;
    tag2_d.dz     = dz1_q;
    tag2_d.is_div = div1_q;
    tag2_d.neg    = neg1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag2_q  <= tag2_d;
      dmag2_q <= dmag1_q;
      bmag2_q <= bmag1_q;
    end
  end

  // ---------------- divider pipeline ----------------
  logic          vd;
  logic [QW-1:0] quo;
  div_tag_t      tagd;

  fpa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .dmag_i  (dmag2_q),
    .bmag_i  (bmag2_q),
    .tag_i   (tag2_q),
    .valid_o (vd),
    .quo_o   (quo),
    .tag_o   (tagd)
  );

  // ---------------- output register ----------------
  logic [31:0] qres;
  logic        out_valid_q;
  alu_out_t    out_q;

  assign qres = tagd.neg ? (~quo[31:0] + 32'd1) : quo[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.result         <= tagd.is_div ? qres : tagd.res;
      out_q.compare_true   <= tagd.cmp;
      out_q.divide_by_zero <= tagd.dz;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the Q24.8 fixed-point ALU: a directed set of edge operands for every
// opcode, then random beats, scored against an in-order queue of predictions.
// ----------------------------------------------------------------------------
module tb;
  import fpa_pkg::*;

  localparam int unsigned N_RANDOM = 550;
  localparam int unsigned LATENCY  = QW + 3;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  alu_in_t  in_i;
  logic     out_valid_o;
  logic     out_stall_i;
  alu_out_t out_o;

  alu_in_t  pending_q[$];
  alu_out_t alu_expect_q[$];
  bit       mismatch_seen;
  bit       calm_phase;
  int       in_idle_left;
  int       out_stall_left;
  logic     in_fire;

  fixed_point_q24_8_alu u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predict the result of one operation
  function automatic alu_out_t alu_predict(alu_in_t op);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] wide;
    alu_out_t r;
    a    = op.operand_a;
    b    = op.operand_b;
    wide = '0;
    r    = '0;
    case (op_e'(op.kind))
      OP_ADD:      wide = a + b;
      OP_SUB:      wide = a - b;
      OP_MUL:      wide = (a * b) / (64'sd1 <<< FRAC_BITS);
      OP_DIV: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else wide = (a <<< FRAC_BITS) / b;
      end
      OP_EQ:       r.compare_true = (a == b);
      OP_NE:       r.compare_true = (a != b);
      OP_LT:       r.compare_true = (a < b);
      OP_GT:       r.compare_true = (a > b);
      OP_LE:       r.compare_true = (a <= b);
      OP_GE:       r.compare_true = (a >= b);
      OP_MIN:      wide = (a > b) ? b : a;
      OP_MAX:      wide = (a < b) ? b : a;
      OP_INC:      wide = a + 1;
      OP_DEC:      wide = a - 1;
      OP_TO_INT:   wide = a >>> FRAC_BITS;
      OP_FROM_INT: wide = a <<< FRAC_BITS;
      default:     wide = '0;
    endcase
    r.result = wide[31:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 2047)) - 1024);
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Input handshake seen at the rising edge; predict each accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        alu_expect_q.push_back(alu_predict(in_i));
      end
    end
  end

  // Driver: one beat per accepted handshake, random idle bursts
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      in_i         <= '0;
      in_idle_left <= 0;
    end else begin
      if (in_valid_i && !in_fire) begin
        // hold the stalled beat
      end else if (in_idle_left > 0) begin
        in_valid_i   <= 1'b0;
        in_idle_left <= in_idle_left - 1;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        in_valid_i   <= 1'b0;
        in_idle_left <= $urandom_range(0, 7);
      end else if (pending_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_i       <= pending_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      out_stall_left <= 0;
    end else if (out_stall_left > 0) begin
      out_stall_i    <= 1'b1;
      out_stall_left <= out_stall_left - 1;
    end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
      out_stall_i    <= 1'b1;
      out_stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    alu_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (alu_expect_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, out_o);
        mismatch_seen = 1'b1;
      end else begin
        want = alu_expect_q.pop_front();
        if (out_o.result !== want.result) begin
          $display("%0t: result expected %h actual %h", $time, want.result, out_o.result);
          mismatch_seen = 1'b1;
        end
        if (out_o.compare_true !== want.compare_true) begin
          $display("%0t: compare_true expected %b actual %b", $time,
                   want.compare_true, out_o.compare_true);
          mismatch_seen = 1'b1;
        end
        if (out_o.divide_by_zero !== want.divide_by_zero) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time,
                   want.divide_by_zero, out_o.divide_by_zero);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    alu_in_t beat;
    int unsigned waited;
    mismatch_seen = 1'b0;
    calm_phase    = 1'b0;
    rst_ni        = 1'b0;
    // directed: every opcode on edge operands, plus division by zero
    for (int k = 0; k < 16; k++) begin
      beat.kind      = 4'(k);
      beat.operand_a = (k % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
      beat.operand_b = (k % 4 < 2) ? 32'hffff_ff00 : 32'h8000_0000;
      pending_q.push_back(beat);
    end
    beat = '{kind: OP_DIV, operand_a: 32'h0000_0100, operand_b: '0};
    pending_q.push_back(beat);
    beat = '{kind: OP_DIV, operand_a: 32'h8000_0000, operand_b: 32'hffff_ffff};
    pending_q.push_back(beat);
    beat = '{kind: OP_MUL, operand_a: 32'hffff_ff80, operand_b: 32'h0000_0001};
    pending_q.push_back(beat);
    beat = '{kind: OP_TO_INT, operand_a: 32'hffff_ff01, operand_b: '0};
    pending_q.push_back(beat);
    beat = '{kind: OP_EQ, operand_a: 32'h1234_5678, operand_b: 32'h1234_5678};
    pending_q.push_back(beat);
    beat = '{kind: OP_MIN, operand_a: 32'h0000_0005, operand_b: 32'h0000_0005};
    pending_q.push_back(beat);
    beat = '{kind: OP_DIV, operand_a: 32'hffff_ff00, operand_b: 32'h0000_0003};
    pending_q.push_back(beat);
    // random beats
    for (int n = 0; n < N_RANDOM; n++) begin
      beat.kind      = 4'($urandom_range(0, 15));
      beat.operand_a = rand_operand();
      beat.operand_b = ($urandom_range(0, 7) == 0) ? beat.operand_a : rand_operand();
      pending_q.push_back(beat);
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // last stretch runs with no idling on either side
    wait (pending_q.size() < 80);
    calm_phase = 1'b1;
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (alu_expect_q.size() == 0);
    waited = 0;
    while (waited < 2 * LATENCY) begin
      @(posedge clk_i);
      waited++;
    end
    if (!mismatch_seen && alu_expect_q.size() == 0) begin
      $display("** fixed_point_q24_8_alu: PASSED **");
    end else begin
      $display("** fixed_point_q24_8_alu: FAILED **");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2_000_000;
    $display("** fixed_point_q24_8_alu: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
design/fpa_pkg.sv
design/fpa_div.sv
design/fixed_point_q24_8_alu.sv
tb/tb.sv
